// ===== hdl/arp_neighbor_cache_core_assert.svh =====
// ----------------------------------------------------------------------------
// ARP neighbor cache assertion macros
// Clocked implication checks for clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ARP_NEIGHBOR_CACHE_CORE_ASSERT_SVH
`define ARP_NEIGHBOR_CACHE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ARPNC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ARPNC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ARPNC_ASSERT_IMP(lbl, ante, cons, msg)
`define ARPNC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hdl/arp_nc_pkg.sv =====
// ----------------------------------------------------------------------------
// ARP neighbor cache package
// Field widths, command, status and register index codes, default depth.
// ----------------------------------------------------------------------------
`default_nettype none

package arp_nc_pkg;

    localparam int IP_W        = 32;
    localparam int MAC_W       = 48;
    localparam int CFG_INDEX_W = 1;
    localparam int ENTRIES_DEF = 16;

    localparam logic [IP_W-1:0]  BCAST_IP  = 32'hFFFF_FFFF;
    localparam logic [MAC_W-1:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [0:0] {
        CMD_LEARN = 1'b0,
        CMD_QUERY = 1'b1
    } command_t;

    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_BCAST     = 3'd1,
        ST_NOT_LOCAL = 3'd2,
        ST_MISS      = 3'd3,
        ST_LEARNED   = 3'd4
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_OWN_IP      = 1'b0,
        REG_SUBNET_MASK = 1'b1
    } reg_index_t;

endpackage

`default_nettype wire

// ===== hdl/arp_neighbor_cache_core.sv =====
// Broadcast and off-subnet queries give their word in the cycle after start.
// Learns and on-subnet queries scan the entry RAM in order, one read a cycle,
// stopping at the first match or once the last entry has been checked.
// busy stays high for the scan; the next start is taken on the done cycle.
// Reset clears the valid bits, the victim pointer and both config registers.
// ----------------------------------------------------------------------------
// ARP neighbor cache core
// IPv4 to MAC cache held in a single-port RAM with per-entry valid flops;
// learn updates, fills or replaces round robin; query resolves, misses, or answers broadcast or off-subnet.
// ----------------------------------------------------------------------------
`default_nettype none

`include "arp_neighbor_cache_core_assert.svh"

module arp_neighbor_cache_core
    import arp_nc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // command channel
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic                   command,
    input  wire logic [IP_W-1:0]        ip_addr,
    input  wire logic [MAC_W-1:0]       mac_addr,
    // result channel
    output logic                        done,
    output logic [2:0]                  status,
    output logic [MAC_W-1:0]            mac_out,
    output logic                        send_request,
    // configuration channel
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [IP_W-1:0]        cfg_data
);

    localparam int IW = $clog2(ENTRIES);
    localparam int DW = IP_W + MAC_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
    localparam logic [IW:0]   END_CNT  = (IW + 1)'(ENTRIES);

    typedef enum logic [0:0] {
        S_IDLE,
        S_SCAN
    } state_t;

    // control registers
    state_t             state_reg,      state_next;
    logic [IW:0]        issue_cnt_reg,  issue_cnt_next;
    logic               chk_pend_reg,   chk_pend_next;
    logic               free_found_reg, free_found_next;
    logic [IW-1:0]      free_idx_reg,   free_idx_next;
    logic [IW-1:0]      victim_reg,     victim_next;
    logic [ENTRIES-1:0] valid_reg,      valid_next;
    logic [IP_W-1:0]    own_ip_reg,     own_ip_next;
    logic [IP_W-1:0]    mask_reg,       mask_next;
    logic               done_reg,       done_next;
    command_t           cmd_reg,        cmd_next;

    // payload registers
    logic [IP_W-1:0]    ip_reg,         ip_next;
    logic [MAC_W-1:0]   mac_reg,        mac_next;
    status_t            status_reg,     status_next;
    logic [MAC_W-1:0]   mac_out_reg,    mac_out_next;
    logic               send_req_reg,   send_req_next;

    // RAM and read-side registers
    logic [DW-1:0]      mem [ENTRIES];
    logic [DW-1:0]      rd_data_reg;
    logic               chk_valid_reg;
    logic [IW-1:0]      chk_idx_reg;

    logic               accept;
    logic               rd_en;
    logic               wr_en;
    logic [IW-1:0]      wr_idx;
    logic [IW-1:0]      rd_idx;
    logic               rd_hit;
    logic               cur_free;
    logic               finish;
    logic [IP_W-1:0]    rd_ip;
    logic [MAC_W-1:0]   rd_mac;
    logic               is_local;

    assign busy         = (state_reg != S_IDLE);
    assign accept       = start && !busy;
    assign cfg_ready    = 1'b1;
    assign done         = done_reg;
    assign status       = status_reg;
    assign mac_out      = mac_out_reg;
    assign send_request = send_req_reg;

    assign rd_ip    = rd_data_reg[DW-1:MAC_W];
    assign rd_mac   = rd_data_reg[MAC_W-1:0];
    assign rd_idx   = issue_cnt_reg[IW-1:0];
    assign is_local = ((own_ip_reg & mask_reg) == (ip_addr & mask_reg));

    // compare the word returned for the entry under check
    assign rd_hit   = chk_pend_reg && chk_valid_reg && (rd_ip == ip_reg);
    assign cur_free = chk_pend_reg && !chk_valid_reg;
    assign finish   = (state_reg == S_SCAN)
                      && (rd_hit || (chk_pend_reg && (chk_idx_reg == LAST_IDX)));
    assign rd_en    = (state_reg == S_SCAN) && !finish && (issue_cnt_reg < END_CNT);
    assign wr_en    = finish && (cmd_reg == CMD_LEARN);

    // next-state logic
    always_comb
    begin
        state_next      = state_reg;
        issue_cnt_next  = issue_cnt_reg;
        chk_pend_next   = rd_en;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        victim_next     = victim_reg;
        valid_next      = valid_reg;
        own_ip_next     = own_ip_reg;
        mask_next       = mask_reg;
        done_next       = 1'b0;
        cmd_next        = cmd_reg;
        ip_next         = ip_reg;
        mac_next        = mac_reg;
        status_next     = status_reg;
        mac_out_next    = mac_out_reg;
        send_req_next   = send_req_reg;
        wr_idx          = victim_reg;

        // take config words
        if (cfg_valid && cfg_ready)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_OWN_IP:      own_ip_next = cfg_data;
                REG_SUBNET_MASK: mask_next   = cfg_data;
                default:         ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = command_t'(command);
                    ip_next  = ip_addr;
                    mac_next = mac_addr;
                    if (command_t'(command) == CMD_QUERY && ip_addr == BCAST_IP)
                    begin
                        done_next     = 1'b1;
                        status_next   = ST_BCAST;
                        mac_out_next  = BCAST_MAC;
                        send_req_next = 1'b0;
                    end
                    else if (command_t'(command) == CMD_QUERY && !is_local)
                    begin
                        done_next     = 1'b1;
                        status_next   = ST_NOT_LOCAL;
                        mac_out_next  = '0;
                        send_req_next = 1'b0;
                    end
                    else
                    begin
                        state_next      = S_SCAN;
                        issue_cnt_next  = '0;
                        free_found_next = 1'b0;
                    end
                end
            end

            S_SCAN:
            begin
                // advance the read pointer
                if (rd_en)
                begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end

                // note the lowest free entry
                if (cur_free && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = chk_idx_reg;
                end

                if (finish)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    if (cmd_reg == CMD_LEARN)
                    begin
                        // pick slot: match, then free, then victim
                        if (rd_hit)
                        begin
                            wr_idx = chk_idx_reg;
                        end
                        else if (free_found_reg)
                        begin
                            wr_idx = free_idx_reg;
                        end
                        else if (cur_free)
                        begin
                            wr_idx = chk_idx_reg;
                        end
                        else
                        begin
                            wr_idx      = victim_reg;
                            victim_next = (victim_reg == LAST_IDX) ? '0
                                                                   : victim_reg + 1'b1;
                        end
                        valid_next[wr_idx] = 1'b1;
                        status_next        = ST_LEARNED;
                        mac_out_next       = '0;
                        send_req_next      = 1'b0;
                    end
                    else if (rd_hit && rd_mac != '0)
                    begin
                        status_next   = ST_HIT;
                        mac_out_next  = rd_mac;
                        send_req_next = 1'b0;
                    end
                    else
                    begin
                        status_next   = ST_MISS;
                        mac_out_next  = '0;
                        send_req_next = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            issue_cnt_reg  <= '0;
            chk_pend_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            victim_reg     <= '0;
            valid_reg      <= '0;
            own_ip_reg     <= '0;
            mask_reg       <= '0;
            done_reg       <= 1'b0;
            cmd_reg        <= CMD_LEARN;
        end
        else
        begin
            state_reg      <= state_next;
            issue_cnt_reg  <= issue_cnt_next;
            chk_pend_reg   <= chk_pend_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            victim_reg     <= victim_next;
            valid_reg      <= valid_next;
            own_ip_reg     <= own_ip_next;
            mask_reg       <= mask_next;
            done_reg       <= done_next;
            cmd_reg        <= cmd_next;
        end
    end

    // hold item and result payload
    always_ff @(posedge clk)
    begin
        ip_reg       <= ip_next;
        mac_reg      <= mac_next;
        status_reg   <= status_next;
        mac_out_reg  <= mac_out_next;
        send_req_reg <= send_req_next;
    end

    // entry RAM: one write or one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= {ip_reg, mac_reg};
        end
        if (rd_en)
        begin
            rd_data_reg   <= mem[rd_idx];
            chk_valid_reg <= valid_reg[rd_idx];
            chk_idx_reg   <= rd_idx;
        end
    end

    // checks
    `ARPNC_ASSERT_NXT(a_scan_on_lookup, accept && (command_t'(command) == CMD_LEARN), state_reg == S_SCAN, "learn did not start a scan")
    `ARPNC_ASSERT_IMP(a_write_in_scan, wr_en, (state_reg == S_SCAN) && finish, "RAM written outside a scan finish")
    `ARPNC_ASSERT_IMP(a_done_idle, done_reg, state_reg == S_IDLE, "result word while scanning")
    `ARPNC_ASSERT_IMP(a_req_miss, done_reg && send_req_reg, status_reg == ST_MISS, "request without miss")
    `ARPNC_ASSERT_NXT(a_learn_sets_valid, wr_en, valid_reg != '0, "learn left no valid entry")

endmodule

`default_nettype wire
